>>> sv/c8cpu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8cpu_pkg
// Shared types, opcode codes and the hex font for the CHIP-8 core.
// ----------------------------------------------------------------------------
package c8cpu_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned MEM_BYTES       = 4096;
  localparam int unsigned SCREEN_WIDTH    = 64;
  localparam int unsigned SCREEN_HEIGHT   = 32;
  localparam int unsigned MEM_AW          = $clog2(MEM_BYTES);
  localparam int unsigned ROW_AW          = $clog2(SCREEN_HEIGHT);
  localparam int unsigned COL_AW          = $clog2(SCREEN_WIDTH);
  localparam int unsigned FONT_BYTES      = 80;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic [MEM_AW-1:0] PC_RESET = 12'h200;

  typedef enum logic [2:0] {
    CMD_CYCLE   = 3'd0,
    CMD_PRESS   = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_MEM_WR  = 3'd3,
    CMD_MEM_RD  = 3'd4,
    CMD_ROW_RD  = 3'd5
  } cmd_e;

  // instruction groups (top nibble)
  localparam logic [3:0] G_SYS  = 4'h0;
  localparam logic [3:0] G_JMP  = 4'h1;
  localparam logic [3:0] G_CALL = 4'h2;
  localparam logic [3:0] G_SEQI = 4'h3;
  localparam logic [3:0] G_SNEI = 4'h4;
  localparam logic [3:0] G_SEQR = 4'h5;
  localparam logic [3:0] G_LDI  = 4'h6;
  localparam logic [3:0] G_ADDI = 4'h7;
  localparam logic [3:0] G_ALU  = 4'h8;
  localparam logic [3:0] G_SNER = 4'h9;
  localparam logic [3:0] G_LDIX = 4'hA;
  localparam logic [3:0] G_JMPV = 4'hB;
  localparam logic [3:0] G_RND  = 4'hC;
  localparam logic [3:0] G_DRAW = 4'hD;
  localparam logic [3:0] G_KEY  = 4'hE;
  localparam logic [3:0] G_MISC = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_RSB = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] K_DOWN = 8'h9E;
  localparam logic [7:0] K_UP   = 8'hA1;

  localparam logic [7:0] F_GETDT = 8'h07;
  localparam logic [7:0] F_WAIT  = 8'h0A;
  localparam logic [7:0] F_SETDT = 8'h15;
  localparam logic [7:0] F_SETST = 8'h18;
  localparam logic [7:0] F_ADDI  = 8'h1E;
  localparam logic [7:0] F_FONT  = 8'h29;
  localparam logic [7:0] F_BCD   = 8'h33;
  localparam logic [7:0] F_STORE = 8'h55;
  localparam logic [7:0] F_LOAD  = 8'h65;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // power-on content of one memory byte
  function automatic logic [7:0] boot_byte(input logic [MEM_AW-1:0] a);
    logic [7:0] b;
    b = 8'h00;
    if (a < MEM_AW'(FONT_BYTES)) begin
      b = FONT[a[6:0]];
    end
    return b;
  endfunction

endpackage
`default_nettype wire

>>> sv/chip8_cpu_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_cpu_core
// CHIP-8 interpreter core driven by one command item at a time.
// ----------------------------------------------------------------------------
// Each input item carries a command in tuser and answers with exactly one
// result item. The core works on one item at a time and drops tready while
// busy; a finished result waits in an output register so the next item can
// be taken before the result is consumed. After reset the core first walks
// main memory loading the font and zeros, with tready low.
// Steps per item: key, write and row commands run the command and result
// states, a memory read adds a data state, a cycle item in a key wait only
// ticks the timers; an instruction fetches, assembles, executes, ticks the
// timers and returns its result. DXYN adds a read and XOR per sprite row, FX33
// a write per digit, FX55 a write and FX65 a read and load per register V0..VX.
// ----------------------------------------------------------------------------
module chip8_cpu_core #(
  parameter int unsigned STACK_DEPTH = c8cpu_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // key[3:0], address[15:4], data[23:16], row[28:24], random_byte[36:29]
  input  wire logic [c8cpu_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // cmd[2:0]
  input  wire logic [c8cpu_pkg::IN_USER_W-1:0]   s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // program_counter[11:0], read_data[75:12], draw_event[76], buzz_event[77],
  // key_wait[78], stack_fault[79]
  output logic [c8cpu_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o
);
  import c8cpu_pkg::*;

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SIW = $clog2(STACK_DEPTH);

  // sequencer codes
  localparam logic [3:0] S_CLR  = 4'd0;   // power-on memory load
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CMD  = 4'd2;   // non-cycle commands
  localparam logic [3:0] S_MRD  = 4'd3;
  localparam logic [3:0] S_F0   = 4'd4;   // fetch high byte
  localparam logic [3:0] S_F1   = 4'd5;   // fetch low byte
  localparam logic [3:0] S_F2   = 4'd6;   // assemble opcode
  localparam logic [3:0] S_EX   = 4'd7;
  localparam logic [3:0] S_DRD  = 4'd8;   // sprite byte read
  localparam logic [3:0] S_DWR  = 4'd9;   // sprite row XOR
  localparam logic [3:0] S_BCD  = 4'd10;
  localparam logic [3:0] S_STR  = 4'd11;
  localparam logic [3:0] S_LRD  = 4'd12;
  localparam logic [3:0] S_LWR  = 4'd13;
  localparam logic [3:0] S_TICK = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0]        state_q;
  logic [MEM_AW-1:0] clr_q;

  // latched item
  cmd_e              cmd_q;
  logic [3:0]        key_q;
  logic [MEM_AW-1:0] addr_q;
  logic [7:0]        data_q;
  logic [ROW_AW-1:0] row_q;
  logic [7:0]        rnd_q;

  // architectural state
  logic [7:0]        v_q [16];
  logic [15:0]       i_q;
  logic [MEM_AW-1:0] pc_q;
  logic [MEM_AW-1:0] stk_q [STACK_DEPTH];
  logic [SPW-1:0]    sp_q;
  logic [7:0]        dt_q;
  logic [7:0]        st_q;
  logic [15:0]       keys_q;
  logic              wait_q;
  logic [3:0]        wtgt_q;
  logic [SCREEN_WIDTH-1:0] frame_q [SCREEN_HEIGHT];

  // working registers
  logic [7:0]        hi_q;
  logic [15:0]       op_q;
  logic [3:0]        cnt_q;
  logic [7:0]        vx_q;
  logic [7:0]        vy_q;
  logic              draw_q;
  logic              fault_q;
  logic              buzz_q;
  logic [63:0]       rd_q;

  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  // main memory, one write and one registered read port
  logic [7:0]        mem_q [MEM_BYTES];
  logic [7:0]        mem_rdata_q;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [MEM_AW-1:0] mem_raddr;
  logic [7:0]        mem_wdata;

  // opcode fields
  logic [3:0]        op_x;
  logic [3:0]        op_y;
  logic [3:0]        op_n;
  logic [7:0]        op_nn;
  logic [MEM_AW-1:0] op_nnn;
  logic [7:0]        vx;
  logic [7:0]        vy;
  logic [MEM_AW-1:0] pc_next;
  logic [MEM_AW-1:0] pc_skip;
  logic [MEM_AW-1:0] i_off;
  logic [SPW-1:0]    sp_dec;
  logic [8:0]        sum9;
  logic [15:0]       i_sum;

  // BCD digits of the captured Vx
  logic [1:0]        bcd_h;
  logic [6:0]        bcd_r;
  logic [14:0]       bcd_p;
  logic [3:0]        bcd_t;
  logic [6:0]        bcd_u;
  logic [7:0]        bcd_digit;

  // sprite row update
  logic [SCREEN_WIDTH-1:0]   spr_row;
  logic [2*SCREEN_WIDTH-1:0] spr_dbl;
  logic [SCREEN_WIDTH-1:0]   spr_rot;
  logic [ROW_AW-1:0]         spr_y;

  assign op_x    = op_q[11:8];
  assign op_y    = op_q[7:4];
  assign op_n    = op_q[3:0];
  assign op_nn   = op_q[7:0];
  assign op_nnn  = op_q[11:0];
  assign vx      = v_q[op_x];
  assign vy      = v_q[op_y];
  assign pc_next = pc_q + MEM_AW'(2);
  assign pc_skip = pc_q + MEM_AW'(4);
  assign i_off   = i_q[MEM_AW-1:0] + MEM_AW'(cnt_q);
  assign sp_dec  = sp_q - SPW'(1);
  assign sum9    = {1'b0, vx} + {1'b0, vy};
  assign i_sum   = i_q + {8'h00, vx};

  always_comb begin
    bcd_h = (vx_q >= 8'd200) ? 2'd2 : ((vx_q >= 8'd100) ? 2'd1 : 2'd0);
    bcd_r = 7'(vx_q - ((bcd_h == 2'd2) ? 8'd200 : ((bcd_h == 2'd1) ? 8'd100 : 8'd0)));
    bcd_p = 15'(bcd_r) * 15'd205;
    bcd_t = bcd_p[14:11];
    bcd_u = bcd_r - {bcd_t, 3'b000} - {2'b00, bcd_t, 1'b0};
    case (cnt_q)
      4'd0:    bcd_digit = {6'd0, bcd_h};
      4'd1:    bcd_digit = {4'd0, bcd_t};
      default: bcd_digit = {1'b0, bcd_u};
    endcase
  end

  always_comb begin
    spr_row = {mem_rdata_q, {(SCREEN_WIDTH-8){1'b0}}};
    spr_dbl = {spr_row, spr_row} >> vx_q[COL_AW-1:0];
    spr_rot = spr_dbl[SCREEN_WIDTH-1:0];
    spr_y   = vy_q[ROW_AW-1:0] + ROW_AW'(cnt_q);
  end

  // memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 8'h00;
    mem_raddr = pc_q;
    case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = boot_byte(clr_q);
      end
      S_CMD: begin
        mem_we    = (cmd_q == CMD_MEM_WR);
        mem_waddr = addr_q;
        mem_wdata = data_q;
        mem_raddr = addr_q;
      end
      S_F1:  mem_raddr = pc_q + MEM_AW'(1);
      S_DRD: mem_raddr = i_off;
      S_LRD: mem_raddr = i_off;
      S_BCD: begin
        mem_we    = 1'b1;
        mem_waddr = i_off;
        mem_wdata = bcd_digit;
      end
      S_STR: begin
        mem_we    = 1'b1;
        mem_waddr = i_off;
        mem_wdata = v_q[cnt_q];
      end
      default: mem_raddr = pc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  // return stack, written on a call that has room
  always_ff @(posedge clk_i) begin
    if (state_q == S_EX && op_q[15:12] == G_CALL && sp_q < SPW'(STACK_DEPTH)) begin
      stk_q[sp_q[SIW-1:0]] <= pc_next;
    end
  end

  // latched item fields
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q  <= cmd_e'(s_axis_tuser_i);
      key_q  <= s_axis_tdata_i[3:0];
      addr_q <= s_axis_tdata_i[15:4];
      data_q <= s_axis_tdata_i[23:16];
      row_q  <= s_axis_tdata_i[28:24];
      rnd_q  <= s_axis_tdata_i[36:29];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      for (int k = 0; k < 16; k++) begin
        v_q[k] <= 8'h00;
      end
      for (int k = 0; k < int'(SCREEN_HEIGHT); k++) begin
        frame_q[k] <= '0;
      end
      i_q       <= 16'h0000;
      pc_q      <= PC_RESET;
      sp_q      <= '0;
      dt_q      <= 8'h00;
      st_q      <= 8'h00;
      keys_q    <= 16'h0000;
      wait_q    <= 1'b0;
      wtgt_q    <= 4'h0;
      hi_q      <= 8'h00;
      op_q      <= 16'h0000;
      cnt_q     <= 4'h0;
      vx_q      <= 8'h00;
      vy_q      <= 8'h00;
      draw_q    <= 1'b0;
      fault_q   <= 1'b0;
      buzz_q    <= 1'b0;
      rd_q      <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      // drop the result once taken
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + MEM_AW'(1);
          if (clr_q == MEM_AW'(MEM_BYTES - 1)) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            draw_q  <= 1'b0;
            fault_q <= 1'b0;
            buzz_q  <= 1'b0;
            rd_q    <= '0;
            if (cmd_e'(s_axis_tuser_i) == CMD_CYCLE) begin
              state_q <= wait_q ? S_TICK : S_F0;
            end else begin
              state_q <= S_CMD;
            end
          end
        end

        S_CMD: begin
          state_q <= S_DONE;
          case (cmd_q)
            CMD_PRESS: begin
              keys_q[key_q] <= 1'b1;
              if (wait_q) begin
                v_q[wtgt_q] <= {4'h0, key_q};
                wait_q      <= 1'b0;
              end
            end
            CMD_RELEASE: keys_q[key_q] <= 1'b0;
            CMD_MEM_RD:  state_q <= S_MRD;
            CMD_ROW_RD:  rd_q <= frame_q[row_q];
            default: ;
          endcase
        end

        S_MRD: begin
          rd_q    <= {56'd0, mem_rdata_q};
          state_q <= S_DONE;
        end

        S_F0: state_q <= S_F1;

        S_F1: begin
          hi_q    <= mem_rdata_q;
          state_q <= S_F2;
        end

        S_F2: begin
          op_q    <= {hi_q, mem_rdata_q};
          state_q <= S_EX;
        end

        S_EX: begin
          // hold operands for multi-cycle work
          vx_q    <= vx;
          vy_q    <= vy;
          cnt_q   <= 4'h0;
          pc_q    <= pc_next;
          state_q <= S_TICK;
          case (op_q[15:12])
            G_SYS: begin
              if (op_q == OP_CLS) begin
                for (int k = 0; k < int'(SCREEN_HEIGHT); k++) begin
                  frame_q[k] <= '0;
                end
                draw_q <= 1'b1;
              end else if (op_q == OP_RET) begin
                if (sp_q == '0) begin
                  fault_q <= 1'b1;
                end else begin
                  sp_q <= sp_dec;
                  pc_q <= stk_q[sp_dec[SIW-1:0]];
                end
              end
            end
            G_JMP: pc_q <= op_nnn;
            G_CALL: begin
              if (sp_q >= SPW'(STACK_DEPTH)) begin
                fault_q <= 1'b1;
              end else begin
                sp_q <= sp_q + SPW'(1);
                pc_q <= op_nnn;
              end
            end
            G_SEQI: if (vx == op_nn) pc_q <= pc_skip;
            G_SNEI: if (vx != op_nn) pc_q <= pc_skip;
            G_SEQR: if (vx == vy) pc_q <= pc_skip;
            G_LDI:  v_q[op_x] <= op_nn;
            G_ADDI: v_q[op_x] <= vx + op_nn;
            G_ALU: begin
              // flag first, so a result into VF wins
              case (op_n)
                ALU_MOV: v_q[op_x] <= vy;
                ALU_OR:  v_q[op_x] <= vx | vy;
                ALU_AND: v_q[op_x] <= vx & vy;
                ALU_XOR: v_q[op_x] <= vx ^ vy;
                ALU_ADD: begin
                  v_q[15]   <= {7'd0, sum9[8]};
                  v_q[op_x] <= sum9[7:0];
                end
                ALU_SUB: begin
                  v_q[15]   <= {7'd0, vx >= vy};
                  v_q[op_x] <= vx - vy;
                end
                ALU_SHR: begin
                  v_q[15]   <= {7'd0, vx[0]};
                  v_q[op_x] <= {1'b0, vx[7:1]};
                end
                ALU_RSB: begin
                  v_q[15]   <= {7'd0, vy >= vx};
                  v_q[op_x] <= vy - vx;
                end
                ALU_SHL: begin
                  v_q[15]   <= {7'd0, vx[7]};
                  v_q[op_x] <= {vx[6:0], 1'b0};
                end
                default: ;
              endcase
            end
            G_SNER: if (vx != vy) pc_q <= pc_skip;
            G_LDIX: i_q <= {4'h0, op_nnn};
            G_JMPV: pc_q <= MEM_AW'(v_q[0]) + op_nnn;
            G_RND:  v_q[op_x] <= rnd_q & op_nn;
            G_DRAW: begin
              v_q[15] <= 8'h00;
              draw_q  <= 1'b1;
              if (op_n != 4'h0) begin
                state_q <= S_DRD;
              end
            end
            G_KEY: begin
              if (op_nn == K_DOWN && keys_q[vx[3:0]]) begin
                pc_q <= pc_skip;
              end else if (op_nn == K_UP && !keys_q[vx[3:0]]) begin
                pc_q <= pc_skip;
              end
            end
            default: begin
              case (op_nn)
                F_GETDT: v_q[op_x] <= dt_q;
                F_WAIT: begin
                  wait_q <= 1'b1;
                  wtgt_q <= op_x;
                end
                F_SETDT: dt_q <= vx;
                F_SETST: st_q <= vx;
                F_ADDI: begin
                  i_q     <= i_sum;
                  v_q[15] <= {7'd0, i_sum > 16'h0FFF};
                end
                F_FONT:  i_q <= {10'd0, vx[3:0], 2'b00} + {12'd0, vx[3:0]};
                F_BCD:   state_q <= S_BCD;
                F_STORE: state_q <= S_STR;
                F_LOAD:  state_q <= S_LRD;
                default: ;
              endcase
            end
          endcase
        end

        S_DRD: state_q <= S_DWR;

        S_DWR: begin
          // XOR one sprite row, flag any pixel turned off
          if ((frame_q[spr_y] & spr_rot) != '0) begin
            v_q[15] <= 8'h01;
          end
          frame_q[spr_y] <= frame_q[spr_y] ^ spr_rot;
          cnt_q          <= cnt_q + 4'h1;
          state_q        <= (cnt_q + 4'h1 == op_n) ? S_TICK : S_DRD;
        end

        S_BCD: begin
          cnt_q <= cnt_q + 4'h1;
          if (cnt_q == 4'h2) begin
            state_q <= S_TICK;
          end
        end

        S_STR: begin
          cnt_q <= cnt_q + 4'h1;
          if (cnt_q == op_x) begin
            state_q <= S_TICK;
          end
        end

        S_LRD: state_q <= S_LWR;

        S_LWR: begin
          v_q[cnt_q] <= mem_rdata_q;
          cnt_q      <= cnt_q + 4'h1;
          state_q    <= (cnt_q == op_x) ? S_TICK : S_LRD;
        end

        S_TICK: begin
          if (dt_q != 8'h00) begin
            dt_q <= dt_q - 8'h01;
          end
          if (st_q != 8'h00) begin
            st_q   <= st_q - 8'h01;
            buzz_q <= (st_q == 8'h01);
          end
          state_q <= S_DONE;
        end

        S_DONE: begin
          // advance once the output register is free
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {fault_q, wait_q, buzz_q, draw_q, rd_q, pc_q};
            state_q   <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CHIP-8 core: a lookahead copy of the core
// state writes each random instruction where the program counter will fetch
// it, and a second copy predicts every result as items are accepted.
// ----------------------------------------------------------------------------
module tb;
  import c8cpu_pkg::*;

  typedef struct {
    bit         sync;    // hold the sender until every result is back
    logic [2:0] cmd;
    logic [3:0] key;
    logic [11:0] addr;
    logic [7:0] data;
    logic [4:0] row;
    logic [7:0] rnd;
  } cmd_item_t;

  typedef struct {
    logic [11:0] pc;
    logic [63:0] rd;
    logic        draw;
    logic        buzz;
    logic        kwait;
    logic        fault;
  } core_res_t;

  // Index 0: lookahead copy used while building stimulus. Index 1: checker.
  localparam int LOOK = 0;
  localparam int CHK  = 1;
  localparam int DEPTH = STACK_DEPTH_DEF;

  logic [7:0]  mem_m   [2][MEM_BYTES];
  logic [63:0] frame_m [2][SCREEN_HEIGHT];
  logic [7:0]  v_m     [2][16];
  logic [15:0] ir_m    [2];
  logic [11:0] pc_m    [2];
  logic [11:0] stk_m   [2][DEPTH];
  int          sp_m    [2];
  logic [7:0]  dt_m    [2];
  logic [7:0]  st_m    [2];
  logic [15:0] keys_m  [2];
  bit          wait_m  [2];
  logic [3:0]  wtgt_m  [2];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic [IN_DATA_W-1:0] s_data = '0;
  logic [IN_USER_W-1:0] s_user = '0;
  logic m_ready = 1'b0;
  logic s_ready, m_valid;
  logic [OUT_DATA_W-1:0] m_data;

  cmd_item_t pending_q[$];
  core_res_t expected_q[$];
  cmd_item_t cur_item;
  bit in_hs = 1'b0;
  int errors = 0;
  int res_cnt = 0;

  always #5 clk_i = ~clk_i;

  chip8_cpu_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  task automatic clear_core(input int m);
    for (int a = 0; a < MEM_BYTES; a++) mem_m[m][a] = (a < FONT_BYTES) ? FONT[a] : 8'h00;
    for (int r = 0; r < SCREEN_HEIGHT; r++) frame_m[m][r] = '0;
    for (int i = 0; i < 16; i++) v_m[m][i] = '0;
    ir_m[m] = '0;
    pc_m[m] = PC_RESET;
    sp_m[m] = 0;
    dt_m[m] = '0;
    st_m[m] = '0;
    keys_m[m] = '0;
    wait_m[m] = 1'b0;
    wtgt_m[m] = '0;
  endtask

  // Advance one core copy by one command item and report its result.
  task automatic core_step(input int m, input cmd_item_t it, output core_res_t r);
    logic [15:0] op;
    logic [3:0]  x, y, n;
    logic [7:0]  nn, vx, vy, bits;
    logic [11:0] nxt, skp, npc;
    logic [8:0]  sum;
    int          px, py;
    r = '{pc: '0, rd: '0, draw: 1'b0, buzz: 1'b0, kwait: 1'b0, fault: 1'b0};
    case (it.cmd)
      CMD_CYCLE: begin
        if (!wait_m[m]) begin
          op = {mem_m[m][pc_m[m]], mem_m[m][pc_m[m] + 12'd1]};
          x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0];
          vx = v_m[m][x]; vy = v_m[m][y];
          nxt = pc_m[m] + 12'd2;
          skp = pc_m[m] + 12'd4;
          npc = nxt;
          case (op[15:12])
            G_SYS: begin
              if (op == OP_CLS) begin
                for (int i = 0; i < SCREEN_HEIGHT; i++) frame_m[m][i] = '0;
                r.draw = 1'b1;
              end else if (op == OP_RET) begin
                if (sp_m[m] == 0) r.fault = 1'b1;
                else begin
                  sp_m[m]--;
                  npc = stk_m[m][sp_m[m]];
                end
              end
            end
            G_JMP: npc = op[11:0];
            G_CALL: begin
              if (sp_m[m] >= DEPTH) r.fault = 1'b1;
              else begin
                stk_m[m][sp_m[m]] = nxt;
                sp_m[m]++;
                npc = op[11:0];
              end
            end
            G_SEQI: if (vx == nn) npc = skp;
            G_SNEI: if (vx != nn) npc = skp;
            G_SEQR: if (vx == vy) npc = skp;
            G_LDI:  v_m[m][x] = nn;
            G_ADDI: v_m[m][x] = vx + nn;
            G_ALU: begin
              case (n)
                ALU_MOV: v_m[m][x] = vy;
                ALU_OR:  v_m[m][x] = vx | vy;
                ALU_AND: v_m[m][x] = vx & vy;
                ALU_XOR: v_m[m][x] = vx ^ vy;
                ALU_ADD: begin
                  sum = {1'b0, vx} + {1'b0, vy};
                  v_m[m][15] = {7'd0, sum[8]};
                  v_m[m][x] = sum[7:0];
                end
                ALU_SUB: begin
                  v_m[m][15] = {7'd0, vx >= vy};
                  v_m[m][x] = vx - vy;
                end
                ALU_SHR: begin
                  v_m[m][15] = {7'd0, vx[0]};
                  v_m[m][x] = vx >> 1;
                end
                ALU_RSB: begin
                  v_m[m][15] = {7'd0, vy >= vx};
                  v_m[m][x] = vy - vx;
                end
                ALU_SHL: begin
                  v_m[m][15] = {7'd0, vx[7]};
                  v_m[m][x] = vx << 1;
                end
                default: ;
              endcase
            end
            G_SNER: if (vx != vy) npc = skp;
            G_LDIX: ir_m[m] = {4'd0, op[11:0]};
            G_JMPV: npc = {4'd0, v_m[m][0]} + op[11:0];
            G_DRAW: begin
              // XOR the sprite in, wrapping on both axes; VF reports a collision
              v_m[m][15] = 8'd0;
              for (int rr = 0; rr < n; rr++) begin
                bits = mem_m[m][ir_m[m][11:0] + 12'(rr)];
                py = (vy + rr) % SCREEN_HEIGHT;
                for (int c = 0; c < 8; c++) begin
                  if (bits[7-c]) begin
                    px = (vx + c) % SCREEN_WIDTH;
                    if (frame_m[m][py][63-px]) v_m[m][15] = 8'd1;
                    frame_m[m][py][63-px] = ~frame_m[m][py][63-px];
                  end
                end
              end
              r.draw = 1'b1;
            end
            G_KEY: begin
              if (nn == K_DOWN) begin
                if (keys_m[m][vx[3:0]]) npc = skp;
              end else if (nn == K_UP) begin
                if (!keys_m[m][vx[3:0]]) npc = skp;
              end
            end
            G_MISC: begin
              case (nn)
                F_GETDT: v_m[m][x] = dt_m[m];
                F_WAIT: begin
                  wait_m[m] = 1'b1;
                  wtgt_m[m] = x;
                end
                F_SETDT: dt_m[m] = vx;
                F_SETST: st_m[m] = vx;
                F_ADDI: begin
                  ir_m[m] = ir_m[m] + {8'd0, vx};
                  v_m[m][15] = {7'd0, ir_m[m] > 16'h0FFF};
                end
                F_FONT: ir_m[m] = 16'(vx[3:0]) * 16'd5;
                F_BCD: begin
                  mem_m[m][ir_m[m][11:0]]         = vx / 8'd100;
                  mem_m[m][ir_m[m][11:0] + 12'd1] = (vx / 8'd10) % 8'd10;
                  mem_m[m][ir_m[m][11:0] + 12'd2] = vx % 8'd10;
                end
                F_STORE: for (int i = 0; i <= x; i++)
                  mem_m[m][ir_m[m][11:0] + 12'(i)] = v_m[m][i];
                F_LOAD: for (int i = 0; i <= x; i++)
                  v_m[m][i] = mem_m[m][ir_m[m][11:0] + 12'(i)];
                default: ;
              endcase
            end
            default: ;
          endcase
          // the random group bypasses execute: load masked random, step pc
          if (op[15:12] == G_RND) v_m[m][x] = it.rnd & nn;
          pc_m[m] = npc;
        end
        if (dt_m[m] != 0) dt_m[m]--;
        if (st_m[m] != 0) begin
          st_m[m]--;
          if (st_m[m] == 0) r.buzz = 1'b1;
        end
      end
      CMD_PRESS: begin
        keys_m[m][it.key] = 1'b1;
        if (wait_m[m]) begin
          v_m[m][wtgt_m[m]] = {4'd0, it.key};
          wait_m[m] = 1'b0;
        end
      end
      CMD_RELEASE: keys_m[m][it.key] = 1'b0;
      CMD_MEM_WR:  mem_m[m][it.addr] = it.data;
      CMD_MEM_RD:  r.rd = {56'd0, mem_m[m][it.addr]};
      CMD_ROW_RD:  r.rd = frame_m[m][it.row];
      default: ;
    endcase
    r.pc = pc_m[m];
    r.kwait = wait_m[m];
  endtask

  function automatic cmd_item_t rand_item(input logic [2:0] cmd);
    cmd_item_t it;
    it.sync = 1'b0;
    it.cmd  = cmd;
    it.key  = 4'($urandom);
    it.addr = 12'($urandom);
    it.data = 8'($urandom);
    it.row  = 5'($urandom);
    it.rnd  = 8'($urandom);
    return it;
  endfunction

  // Queue an item and move the lookahead copy past it.
  task automatic queue_item(input cmd_item_t it);
    core_res_t r;
    core_step(LOOK, it, r);
    pending_q.push_back(it);
  endtask

  task automatic queue_cmd(input logic [2:0] cmd);
    queue_item(rand_item(cmd));
  endtask

  task automatic queue_write(input logic [11:0] a, input logic [7:0] d);
    cmd_item_t it;
    it = rand_item(CMD_MEM_WR);
    it.addr = a;
    it.data = d;
    queue_item(it);
  endtask

  // Place an instruction where the core fetches next, then queue a cycle command.
  task automatic queue_op(input logic [15:0] op);
    queue_write(pc_m[LOOK], op[15:8]);
    queue_write(pc_m[LOOK] + 12'd1, op[7:0]);
    queue_cmd(CMD_CYCLE);
  endtask

  task automatic queue_sync();
    cmd_item_t it;
    it = rand_item(CMD_CYCLE);
    it.sync = 1'b1;
    pending_q.push_back(it);
  endtask

  function automatic logic [15:0] rand_op();
    logic [3:0] g, x, y, n;
    logic [7:0] nn;
    logic [7:0] alu_codes [9] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
                                  ALU_SUB, ALU_SHR, ALU_RSB, ALU_SHL};
    logic [7:0] misc_codes [9] = '{F_GETDT, F_WAIT, F_SETDT, F_SETST, F_ADDI,
                                   F_FONT, F_BCD, F_STORE, F_LOAD};
    g = 4'($urandom); x = 4'($urandom); y = 4'($urandom);
    n = 4'($urandom); nn = 8'($urandom);
    case (g)
      G_SYS: case ($urandom_range(0, 3))
        0: return OP_CLS;
        1, 2: return OP_RET;
        default: return {G_SYS, x, nn};
      endcase
      G_ALU: begin
        if ($urandom_range(0, 7) != 0) n = alu_codes[$urandom_range(0, 8)][3:0];
        return {g, x, y, n};
      end
      G_DRAW: begin
        n = ($urandom_range(0, 5) == 0) ? 4'hF : 4'($urandom_range(0, 4));
        return {g, x, y, n};
      end
      G_KEY: begin
        if ($urandom_range(0, 7) != 0) nn = $urandom_range(0, 1) ? K_DOWN : K_UP;
        return {g, x, nn};
      end
      G_MISC: begin
        if ($urandom_range(0, 7) != 0) nn = misc_codes[$urandom_range(0, 8)];
        return {g, x, nn};
      end
      default: return {g, x, nn};
    endcase
  endfunction

  // Latch handshakes and predict each accepted item.
  always @(posedge clk_i) begin
    core_res_t r;
    in_hs <= s_valid && s_ready;
    if (rst_ni && s_valid && s_ready) begin
      core_step(CHK, cur_item, r);
      expected_q.push_back(r);
    end
  end

  // Driver: present the next pending item at the falling edge.
  always @(negedge clk_i) begin
    int gap;
    if (!s_valid || in_hs) begin
      if (gap > 0) begin
        gap--;
        s_valid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        s_valid <= 1'b0;
      end else if (pending_q[0].sync) begin
        // pause the sender until the core has answered everything
        s_valid <= 1'b0;
        if (expected_q.size() == 0) void'(pending_q.pop_front());
      end else begin
        cur_item = pending_q.pop_front();
        s_data <= {3'd0, cur_item.rnd, cur_item.row, cur_item.data, cur_item.addr,
                   cur_item.key};
        s_user <= cur_item.cmd;
        s_valid <= 1'b1;
        if (pending_q.size() > 120 && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 9);
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back the core up.
  always @(negedge clk_i) begin
    int rgap;
    int rhold;
    bit long_done;
    if (!long_done && res_cnt >= 300) begin
      long_done = 1'b1;
      rhold = 400;
    end
    if (rhold > 0) begin
      rhold--;
      m_ready <= 1'b0;
    end else if (rgap > 0) begin
      rgap--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
      if (pending_q.size() > 120 && $urandom_range(0, 5) == 0) rgap = $urandom_range(1, 9);
    end
  end

  // Check each result against the oldest prediction.
  always @(posedge clk_i) begin
    core_res_t e;
    if (rst_ni && m_valid && m_ready) begin
      res_cnt++;
      if (expected_q.size() == 0) begin
        $error("unexpected result item %h", m_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (m_data[11:0] !== e.pc) begin
          $error("program_counter exp %h got %h", e.pc, m_data[11:0]);
          errors++;
        end
        if (m_data[75:12] !== e.rd) begin
          $error("read_data exp %h got %h", e.rd, m_data[75:12]);
          errors++;
        end
        if (m_data[76] !== e.draw) begin
          $error("draw_event exp %b got %b", e.draw, m_data[76]);
          errors++;
        end
        if (m_data[77] !== e.buzz) begin
          $error("buzz_event exp %b got %b", e.buzz, m_data[77]);
          errors++;
        end
        if (m_data[78] !== e.kwait) begin
          $error("key_wait exp %b got %b", e.kwait, m_data[78]);
          errors++;
        end
        if (m_data[79] !== e.fault) begin
          $error("stack_fault exp %b got %b", e.fault, m_data[79]);
          errors++;
        end
      end
    end
  end

  initial begin
    cmd_item_t it;
    clear_core(LOOK);
    clear_core(CHK);

    // directed: memory and row extremes, keys, unused commands
    it = rand_item(CMD_MEM_RD); it.addr = 12'h000; queue_item(it);
    queue_write(12'hFFF, 8'hFF);
    it = rand_item(CMD_MEM_RD); it.addr = 12'hFFF; queue_item(it);
    queue_write(12'hFFF, 8'h00);
    it = rand_item(CMD_PRESS); it.key = 4'hF; queue_item(it);
    it = rand_item(CMD_RELEASE); it.key = 4'hF; queue_item(it);
    it = rand_item(CMD_PRESS); it.key = 4'h0; queue_item(it);
    queue_cmd(3'd6);
    queue_cmd(3'd7);
    // subtract with equal operands sets the flag; draw a tall sprite at the corner
    queue_op(16'h603E);
    queue_op(16'h8005);
    queue_op(16'h00EE);      // return on an empty stack
    queue_op(16'hD00F);
    it = rand_item(CMD_ROW_RD); it.row = 5'd0; queue_item(it);
    it = rand_item(CMD_ROW_RD); it.row = 5'd31; queue_item(it);
    queue_op(16'hF50A);      // key wait, then a cycle while halted
    queue_cmd(CMD_CYCLE);
    queue_cmd(CMD_PRESS);

    // random programs, written just ahead of the fetch
    for (int k = 0; k < 300; k++) begin
      if (k == 150) begin
        // call deep enough to overflow the return stack
        for (int c = 0; c < DEPTH + 2; c++)
          queue_op({G_CALL, 12'($urandom)});
      end
      if (k == 200 || $urandom_range(0, 49) == 0) queue_sync();
      if ($urandom_range(0, 5) == 0)
        queue_cmd(3'($urandom_range(1, 7)));
      if (wait_m[LOOK]) begin
        if ($urandom_range(0, 1) == 0) queue_cmd(CMD_CYCLE);
        queue_cmd(CMD_PRESS);
      end else if ($urandom_range(0, 7) == 0) begin
        queue_cmd(CMD_CYCLE);
      end else begin
        queue_op(rand_op());
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() != 0 || s_valid) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** chip8_cpu_core: PASSED **");
    end else begin
      $display("** chip8_cpu_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** chip8_cpu_core: FAILED **");
    $finish;
  end

endmodule
